>>> src/elp_pkg.sv
// Shared types and constants for the edge-list text parser.
// Holds the character codes, the parse phase codes and the result record.
// No dependencies.
package elp_pkg;

    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam logic [1:0] PH_SPACE  = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_IGNORE = 2'd3;

    localparam int WORD_W = 32;

    typedef struct packed {
        logic [WORD_W-1:0] max_node_id;
        logic [WORD_W-1:0] edge_weight;
        logic [WORD_W-1:0] dst_node;
        logic [WORD_W-1:0] src_node;
    } elp_result_t;

endpackage

>>> src/elp_parse_core.sv
// Input register and per-byte line parser for the edge-list text parser.
// Keeps the line state and the running maximum node id; one byte a cycle while out_free is high.
// Depends on elp_pkg.
module elp_parse_core
    import elp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        weighted_mode,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  logic        out_free,
    output logic        res_valid,
    output elp_result_t res_data
);

    logic              s1_valid_reg, s1_valid_next;
    logic [7:0]        s1_byte_reg;
    logic              s1_last_reg;

    logic [1:0]        phase_reg, phase_next;
    logic [1:0]        tok_reg, tok_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic              neg_reg, neg_next;
    logic [WORD_W-1:0] src_reg, src_next;
    logic [WORD_W-1:0] dst_reg, dst_next;
    logic [WORD_W-1:0] max_reg, max_next;

    logic              advance;
    logic              good;

    function automatic logic tokens_met(input logic [1:0] tok, input logic wmode);
        tokens_met = (tok == 2'd3) || ((tok == 2'd2) && !wmode);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    assign advance  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || advance;

    always_comb
    begin
        logic [7:0]        c;
        logic              dig;
        logic              closing;
        logic              do_start;
        logic              do_finish;
        logic [WORD_W-1:0] val;
        logic [WORD_W-1:0] m;

        c        = s1_byte_reg;
        dig      = is_digit(c);
        closing  = (c == CH_NL) || s1_last_reg;
        do_start = 1'b0;
        good     = 1'b0;

        phase_next = phase_reg;
        tok_next   = tok_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        max_next   = max_reg;

        // A newline byte only closes the line; any other byte is parsed first.
        if (c != CH_NL)
        begin
            case (phase_reg)
                PH_SPACE:
                begin
                    do_start = 1'b1;
                end
                PH_SIGN:
                begin
                    if (!tokens_met(tok_reg, weighted_mode) && dig)
                    begin
                        acc_next   = {28'd0, c[3:0]};
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = PH_IGNORE;
                    end
                end
                PH_DIGITS:
                begin
                    if (dig)
                    begin
                        acc_next = {acc_reg[WORD_W-4:0], 3'b000}
                                 + {acc_reg[WORD_W-2:0], 1'b0}
                                 + {28'd0, c[3:0]};
                    end
                    else
                    begin
                        do_start = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IGNORE;
                end
            endcase
        end

        // A non-digit after digits ends the token before it is judged as a new start.
        do_finish = (phase_next == PH_DIGITS) && do_start;
        val = neg_next ? (32'd0 - acc_next) : acc_next;
        if (do_finish)
        begin
            case (tok_next)
                2'd0:
                begin
                    src_next = val;
                    acc_next = '0;
                end
                2'd1:
                begin
                    dst_next = val;
                    acc_next = '0;
                end
                default:
                begin
                    acc_next = val;
                end
            endcase
            neg_next = 1'b0;
            if (tok_next != 2'd3)
            begin
                tok_next = tok_next + 2'd1;
            end
        end

        if (do_start)
        begin
            if (tokens_met(tok_next, weighted_mode))
            begin
                phase_next = PH_IGNORE;
            end
            else if ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR))
            begin
                phase_next = PH_SPACE;
            end
            else if ((c == CH_PLUS) || (c == CH_MINUS))
            begin
                neg_next   = (c == CH_MINUS);
                phase_next = PH_SIGN;
            end
            else if (dig)
            begin
                acc_next   = {28'd0, c[3:0]};
                phase_next = PH_DIGITS;
            end
            else
            begin
                // Comment markers and any other character land here.
                phase_next = PH_IGNORE;
            end
        end

        // A token still open when the line closes ends here, after any new start.
        if (closing && (phase_next == PH_DIGITS))
        begin
            val = neg_next ? (32'd0 - acc_next) : acc_next;
            case (tok_next)
                2'd0:
                begin
                    src_next = val;
                    acc_next = '0;
                end
                2'd1:
                begin
                    dst_next = val;
                    acc_next = '0;
                end
                default:
                begin
                    acc_next = val;
                end
            endcase
            neg_next = 1'b0;
            if (tok_next != 2'd3)
            begin
                tok_next = tok_next + 2'd1;
            end
        end

        m = max_reg;
        if (closing)
        begin
            good = tokens_met(tok_next, weighted_mode);
            if (good)
            begin
                if ($signed(src_next) > $signed(m))
                begin
                    m = src_next;
                end
                if ($signed(dst_next) > $signed(m))
                begin
                    m = dst_next;
                end
                max_next = m;
            end
        end

        res_data.src_node    = src_next;
        res_data.dst_node    = dst_next;
        res_data.edge_weight = weighted_mode ? acc_next : 32'd1;
        res_data.max_node_id = m;

        if (closing)
        begin
            phase_next = PH_SPACE;
            tok_next   = 2'd0;
            acc_next   = '0;
            neg_next   = 1'b0;
        end
    end

    assign res_valid = advance && good;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            phase_reg    <= PH_SPACE;
            tok_reg      <= 2'd0;
            acc_reg      <= '0;
            neg_reg      <= 1'b0;
            src_reg      <= '0;
            dst_reg      <= '0;
            max_reg      <= '1;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (advance)
            begin
                phase_reg <= phase_next;
                tok_reg   <= tok_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                src_reg   <= src_next;
                dst_reg   <= dst_next;
                max_reg   <= max_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= in_byte;
            s1_last_reg <= in_last;
        end
    end

endmodule

>>> src/elp_out_reg.sv
// Result register for the edge-list text parser.
// Holds one finished edge record until the downstream side takes it.
// Depends on elp_pkg.
module elp_out_reg
    import elp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  elp_result_t load_data,
    output logic        free,
    output logic        valid,
    input  logic        ready,
    output elp_result_t data
);

    logic        valid_reg, valid_next;
    elp_result_t data_reg;

    // The register can take a new record when empty or when its beat completes now.
    assign free  = !valid_reg || ready;
    assign valid = valid_reg;
    assign data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

>>> src/edge_list_text_parser.sv
// Top level of the edge-list text parser: byte stream in, edge records out.
// Depends on elp_pkg, elp_parse_core and elp_out_reg.
//
//  Channel  Direction  Beat contents
//  s_*      in         tdata[7:0] data_byte, tlast last_byte
//  m_*      out        tdata src_node, dst_node, edge_weight, max_node_id (32 bits each)
//  cfg_*    in         cfg_wdata weighted_mode, written when cfg_wen is high
//
// One byte is taken every cycle while m_tready is high. A byte that closes a
// good line shows its record on m_* in this order: the input register takes
// the byte, then the result register loads the record once it is free.
// Reset clears the line state and sets the maximum node id to minus one.
// While the result register holds a beat that m_tready does not take, the
// byte in the input register cannot move on, so s_tready is low; an empty
// input register still takes one byte.
module edge_list_text_parser
    import elp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wen,
    input  logic         cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // src_node, dst_node, edge_weight, max_node_id
);

    logic        weighted_reg;
    logic        out_free;
    logic        res_valid;
    elp_result_t res_data;
    elp_result_t out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weighted_reg <= 1'b0;
        end
        else if (cfg_wen)
        begin
            weighted_reg <= cfg_wdata;
        end
    end

    elp_parse_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .weighted_mode (weighted_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_byte       (s_tdata),
        .in_last       (s_tlast),
        .out_free      (out_free),
        .res_valid     (res_valid),
        .res_data      (res_data)
    );

    elp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_data (res_data),
        .free      (out_free),
        .valid     (m_tvalid),
        .ready     (m_tready),
        .data      (out_data)
    );

    assign m_tdata = out_data;

endmodule

>>> test/edge_list_text_parser_tb.sv
// Self-checking testbench for edge_list_text_parser: drives edge-list text byte by byte,
// predicts every edge record and compares each result beat with the oldest prediction.
// Depends on elp_pkg and the edge_list_text_parser RTL.
`timescale 1ns / 100ps

module edge_list_text_parser_tb;

    import elp_pkg::*;

    localparam int         PHASE_BYTES = 256;
    localparam int         STALL_LIMIT = 3000;
    localparam int         HOLD_CYCLES = 80;
    // Weighted mode used in each random phase, phase 0 in bit 0.
    localparam logic [5:0] MODE_PLAN   = 6'b010101;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_beat_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        logic        typed;
        elp_result_t want;
    } text_row_t;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         cfg_wen   = 1'b0;
    logic         cfg_wdata = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata   = 8'd0;   // [7:0] data_byte
    logic         s_tlast   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [127:0] m_tdata;            // src_node, dst_node, edge_weight, max_node_id

    // Handshake state captured at the falling edge, valid for the next rising edge.
    logic        in_fire  = 1'b0;
    logic        out_fire = 1'b0;
    elp_result_t out_word = '0;

    elp_result_t edge_q[$];
    text_beat_t  text_q[$];
    text_row_t   text_rows[$];

    int   errors      = 0;
    int   idle_cycles = 0;
    int   hold_left   = 0;
    logic hold_req    = 1'b0;
    logic gaps_on     = 1'b1;

    // Predictor state.
    logic        mode_w   = 1'b0;
    logic [1:0]  st       = PH_SPACE;
    logic [1:0]  tok_seen = 2'd0;
    logic [31:0] acc      = 32'd0;
    logic        neg      = 1'b0;
    logic [31:0] src_hold = 32'd0;
    logic [31:0] dst_hold = 32'd0;
    logic [31:0] top_id   = 32'hFFFF_FFFF;

    edge_list_text_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        in_fire  = s_tvalid && s_tready;
        out_fire = m_tvalid && m_tready;
        out_word = m_tdata;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic blank_ch(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR;
    endfunction

    function automatic logic digit_ch(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic [1:0] tokens_wanted();
        return mode_w ? 2'd3 : 2'd2;
    endfunction

    task automatic close_token();
        logic [31:0] v;
        v = neg ? 32'd0 - acc : acc;
        case (tok_seen)
            2'd0:
            begin
                src_hold = v;
                acc      = 32'd0;
            end
            2'd1:
            begin
                dst_hold = v;
                acc      = 32'd0;
            end
            default:
                acc = v;
        endcase
        neg = 1'b0;
        if (tok_seen != 2'd3)
            tok_seen = tok_seen + 2'd1;
    endtask

    task automatic open_token(input logic [7:0] c);
        if (tok_seen >= tokens_wanted())
            st = PH_IGNORE;
        else if (blank_ch(c))
            st = PH_SPACE;
        else if (c == CH_PLUS || c == CH_MINUS)
        begin
            neg = (c == CH_MINUS);
            st  = PH_SIGN;
        end
        else if (digit_ch(c))
        begin
            acc = {24'd0, c - CH_ZERO};
            st  = PH_DIGITS;
        end
        else
            st = PH_IGNORE;
    endtask

    task automatic take_char(input logic [7:0] c);
        case (st)
            PH_SPACE:
                open_token(c);
            PH_SIGN:
                if (tok_seen < tokens_wanted() && digit_ch(c))
                begin
                    acc = {24'd0, c - CH_ZERO};
                    st  = PH_DIGITS;
                end
                else
                    st = PH_IGNORE;
            PH_DIGITS:
                if (digit_ch(c))
                    acc = acc * 32'd10 + {24'd0, c - CH_ZERO};
                else
                begin
                    close_token();
                    open_token(c);
                end
            default:
                st = PH_IGNORE;
        endcase
    endtask

    task automatic close_line(output logic got, output elp_result_t r);
        got = 1'b0;
        r   = '0;
        if (st == PH_DIGITS)
            close_token();
        if (tok_seen >= tokens_wanted())
        begin
            if ($signed(src_hold) > $signed(top_id))
                top_id = src_hold;
            if ($signed(dst_hold) > $signed(top_id))
                top_id = dst_hold;
            r.src_node    = src_hold;
            r.dst_node    = dst_hold;
            r.edge_weight = mode_w ? acc : 32'd1;
            r.max_node_id = top_id;
            got = 1'b1;
        end
        st       = PH_SPACE;
        tok_seen = 2'd0;
        acc      = 32'd0;
        neg      = 1'b0;
    endtask

    task automatic parse_byte(input logic [7:0] c, input logic last,
                              output logic got, output elp_result_t r);
        got = 1'b0;
        r   = '0;
        if (c == CH_NL)
            close_line(got, r);
        else
        begin
            take_char(c);
            if (last)
                close_line(got, r);
        end
    endtask

    // ---------------------------------------------------------------- checking

    always @(posedge clk)
    begin
        elp_result_t want;
        if (out_fire)
        begin
            if (edge_q.size() == 0)
            begin
                errors = errors + 1;
                if (errors <= 10)
                    $display("unexpected edge beat: src %0d dst %0d wt %0d max %0d",
                             $signed(out_word.src_node), $signed(out_word.dst_node),
                             $signed(out_word.edge_weight), $signed(out_word.max_node_id));
            end
            else
            begin
                want = edge_q.pop_front();
                if (want.src_node != out_word.src_node || want.dst_node != out_word.dst_node
                    || want.edge_weight != out_word.edge_weight
                    || want.max_node_id != out_word.max_node_id)
                begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("edge mismatch: want %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                 $signed(want.src_node), $signed(want.dst_node),
                                 $signed(want.edge_weight), $signed(want.max_node_id),
                                 $signed(out_word.src_node), $signed(out_word.dst_node),
                                 $signed(out_word.edge_weight), $signed(out_word.max_node_id));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (in_fire || out_fire)
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= !gaps_on || ($urandom_range(99) >= 22);
    end

    // ---------------------------------------------------------------- stimulus

    task automatic send_byte(input logic [7:0] c, input logic last,
                             output logic got, output elp_result_t r);
        while (gaps_on && $urandom_range(99) < 22)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!in_fire);
        parse_byte(c, last, got, r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (edge_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        cfg_wen   <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        mode_w    = m;
    endtask

    task automatic add_row(input logic [7:0] c, input logic last);
        text_row_t row;
        row       = '0;
        row.ch    = c;
        row.last  = last;
        text_rows.insert(text_rows.size(), row);
    endtask

    task automatic add_row_edge(input logic [7:0] c, input logic last,
                                input logic [31:0] src, input logic [31:0] dst,
                                input logic [31:0] wt, input logic [31:0] mx);
        text_row_t row;
        row                  = '0;
        row.ch               = c;
        row.last             = last;
        row.typed            = 1'b1;
        row.want.src_node    = src;
        row.want.dst_node    = dst;
        row.want.edge_weight = wt;
        row.want.max_node_id = mx;
        text_rows.insert(text_rows.size(), row);
    endtask

    task automatic put(input logic [7:0] c);
        text_beat_t b;
        b.ch   = c;
        b.last = 1'b0;
        text_q.insert(text_q.size(), b);
    endtask

    task automatic put_blanks(input int min_n);
        int          n;
        logic [1:0]  k;
        n = $urandom_range(min_n + 2, min_n);
        repeat (n)
        begin
            k = 2'($urandom_range(2));
            put(k == 0 ? CH_SPACE : (k == 1 ? CH_TAB : CH_CR));
        end
    endtask

    // Sign code: 0 none, 1 minus, 2 plus. Mostly short numbers, a few that wrap.
    task automatic put_token(input int sign_code);
        int         k;
        int         n;
        logic [7:0] d;
        k = $urandom_range(19);
        if (k < 14)
            n = $urandom_range(3, 1);
        else if (k < 18)
            n = $urandom_range(9, 4);
        else
            n = $urandom_range(12, 10);
        if (sign_code == 1)
            put(CH_MINUS);
        else if (sign_code == 2)
            put(CH_PLUS);
        repeat (n)
        begin
            d = 8'($urandom_range(9));
            put(CH_ZERO + d);
        end
    endtask

    function automatic int pick_sign();
        int k;
        k = $urandom_range(9);
        return k < 2 ? 1 : (k == 2 ? 2 : 0);
    endfunction

    task automatic end_line();
        int         k;
        text_beat_t b;
        k = $urandom_range(15);
        if (k == 0 && text_q.size() != 0)
        begin
            // The closing byte itself carries the end-of-block mark.
            b      = text_q.pop_back();
            b.last = 1'b1;
            text_q.insert(text_q.size(), b);
        end
        else if (k == 1)
        begin
            b.ch   = CH_NL;
            b.last = 1'b1;
            text_q.insert(text_q.size(), b);
        end
        else
            put(CH_NL);
    endtask

    task automatic gen_line();
        int         kind;
        int         ntok;
        int         sgn;
        int         n;
        logic [7:0] b;
        kind = $urandom_range(99);
        if (kind < 70)
        begin
            if ($urandom_range(3) == 0)
                put_blanks(0);
            ntok = $urandom_range(4, 1);
            for (int i = 0; i < ntok; i++)
            begin
                sgn = pick_sign();
                if (i > 0 && !(sgn != 0 && $urandom_range(3) == 0))
                    put_blanks(1);
                put_token(sgn);
            end
            if ($urandom_range(4) == 0)
            begin
                put_blanks(1);
                n = $urandom_range(5, 1);
                repeat (n)
                begin
                    b = 8'($urandom_range(126, 33));
                    put(b);
                end
            end
            else if ($urandom_range(3) == 0)
                put_blanks(0);
            end_line();
        end
        else if (kind < 80)
        begin
            // Comment line.
            put_blanks(0);
            put($urandom_range(1) ? CH_HASH : CH_PERCENT);
            n = $urandom_range(6, 1);
            repeat (n)
            begin
                do
                    b = 8'($urandom_range(255));
                while (b == CH_NL);
                put(b);
            end
            end_line();
        end
        else if (kind < 85)
        begin
            put_blanks(0);
            end_line();
        end
        else if (kind < 93)
        begin
            n = $urandom_range(8, 1);
            repeat (n)
            begin
                b = 8'($urandom_range(255));
                put(b);
            end
            end_line();
        end
        else
        begin
            // A sign that is not followed by a digit.
            put_token(pick_sign());
            put_blanks(1);
            put($urandom_range(1) ? CH_MINUS : CH_PLUS);
            n = $urandom_range(2);
            if (n == 1)
                put_blanks(1);
            else if (n == 2)
            begin
                b = 8'($urandom_range(122, 97));
                put(b);
            end
            if ($urandom_range(1))
            begin
                put_blanks(1);
                put_token(0);
            end
            end_line();
        end
    endtask

    initial
    begin
        text_row_t   row;
        text_beat_t  tb;
        elp_result_t r;
        logic        got;
        int          ntok;
        int          idx;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed text, weighted mode off after reset.
        add_row(CH_NL, 1'b0);                                         // blank line
        add_row(CH_HASH, 1'b0);
        add_row(CH_NL, 1'b0);
        add_row(CH_PERCENT, 1'b0);
        add_row(CH_NL, 1'b0);
        add_row("3", 1'b0);                                           // "3-4": two tokens
        add_row(CH_MINUS, 1'b0);
        add_row("4", 1'b0);
        add_row_edge(CH_NL, 1'b0, 32'd3, 32'hFFFF_FFFC, 32'd1, 32'd3);
        add_row(CH_MINUS, 1'b0);                                      // sign at line end
        add_row(CH_NL, 1'b0);
        add_row("9", 1'b0);                                           // bad second token
        add_row(CH_TAB, 1'b0);
        add_row(8'hFF, 1'b0);
        add_row(CH_NL, 1'b0);
        add_row("7", 1'b0);                                           // closed by block end
        add_row(CH_SPACE, 1'b0);
        add_row_edge("8", 1'b1, 32'd7, 32'd8, 32'd1, 32'd8);
        add_row("1", 1'b0);
        add_row(CH_CR, 1'b0);
        add_row("2", 1'b0);
        add_row_edge(8'h00, 1'b1, 32'd1, 32'd2, 32'd1, 32'd8);

        foreach (text_rows[i])
        begin
            row = text_rows[i];
            send_byte(row.ch, row.last, got, r);
            if (row.typed)
                edge_q.insert(edge_q.size(), row.want);
            else if (got)
                edge_q.insert(edge_q.size(), r);
        end

        for (int p = 0; p < 6; p++)
        begin
            drain();
            write_mode(MODE_PLAN[p]);
            gaps_on = (p != 2);
            text_q.delete();
            while (text_q.size() < PHASE_BYTES)
                gen_line();
            // Leave a line open so that the next mode decides how it closes.
            ntok = $urandom_range(3, 1);
            for (int i = 0; i < ntok; i++)
            begin
                if (i > 0)
                    put_blanks(1);
                put_token(pick_sign());
            end
            idx = 0;
            while (text_q.size() != 0)
            begin
                tb = text_q.pop_front();
                send_byte(tb.ch, tb.last, got, r);
                if (got)
                    edge_q.insert(edge_q.size(), r);
                idx = idx + 1;
                if (p == 3 && idx == 60)
                    hold_req = 1'b1;
            end
        end
        drain();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
